FILE: design/mpeg_audio_frame_sync_top_assert.svh
// Assertion macros shared by the frame synchronizer modules.
`ifndef MPEG_AUDIO_FRAME_SYNC_TOP_ASSERT_SVH
`define MPEG_AUDIO_FRAME_SYNC_TOP_ASSERT_SVH

// Clocked property check, disabled while reset is asserted.
`define MAFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true at a clock edge.
`define MAFS_NEVER(label, cond, msg) \
    `MAFS_ASSERT(label, !(cond), msg)

`endif

FILE: design/mafs_pkg.sv
// Types, constants and table functions of the MPEG audio frame synchronizer.
`default_nettype none

package mafs_pkg;

    // Largest frame length accepted as a legal header.
    localparam int MAX_FRAME_BYTES = 4096;

    // Field widths.
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int KBPS_W    = 9;
    localparam int COEF_W    = 18;
    localparam int NUM_W     = 27;
    localparam int RATE_W    = 16;
    localparam int QUO_W     = 12;
    localparam int HDR_BYTES = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_SKIP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID3_LEN  = 2'd1;

    // Register reset values and the shortest block.
    localparam logic [LEN_W-1:0] TAG_SKIP_RESET = 12'd128;
    localparam logic [LEN_W-1:0] ID3_LEN_RESET  = 12'd24;
    localparam logic [LEN_W-1:0] MIN_BLOCK      = 12'(HDR_BYTES);

    // Header markers.
    localparam logic [7:0] SYNC_BYTE = 8'hff;
    localparam logic [7:0] SYNC_MASK = 8'he0;
    localparam logic [7:0] CHAR_T = 8'h54;
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_3 = 8'h33;

    // Header field codes.
    localparam logic [1:0] VER_MPEG1    = 2'd3;
    localparam logic [1:0] VER_MPEG2    = 2'd2;
    localparam logic [1:0] VER_RESERVED = 2'd1;
    localparam logic [1:0] LAY_I        = 2'd3;
    localparam logic [1:0] LAY_III      = 2'd1;
    localparam logic [1:0] LAY_RESERVED = 2'd0;
    localparam logic [1:0] SRI_RESERVED = 2'd3;
    localparam logic [3:0] BRI_FREE     = 4'd0;
    localparam logic [3:0] BRI_BAD      = 4'd15;

    // Bytes per kbps and per Hz: Layer I counts four-byte slots.
    localparam logic [COEF_W-1:0] COEF_L1     = COEF_W'(384 * 1000 / 8 / 4);
    localparam logic [COEF_W-1:0] COEF_L3_LSF = COEF_W'(576 * 1000 / 8);
    localparam logic [COEF_W-1:0] COEF_STD    = COEF_W'(1152 * 1000 / 8);

    // Output block kinds.
    localparam logic KIND_AUDIO = 1'b0;
    localparam logic KIND_ID3   = 1'b1;

    // Bitrate rows, index 15 leftmost.
    localparam logic [15:0][KBPS_W-1:0] KBPS_ROW0 = {
        9'd0, 9'd448, 9'd416, 9'd384, 9'd352, 9'd320, 9'd288, 9'd256,
        9'd224, 9'd192, 9'd160, 9'd128, 9'd96, 9'd64, 9'd32, 9'd0};
    localparam logic [15:0][KBPS_W-1:0] KBPS_ROW1 = {
        9'd0, 9'd384, 9'd320, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128,
        9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd32, 9'd0};
    localparam logic [15:0][KBPS_W-1:0] KBPS_ROW2 = {
        9'd0, 9'd320, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128, 9'd112,
        9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd0};
    localparam logic [15:0][KBPS_W-1:0] KBPS_ROW3 = {
        9'd0, 9'd256, 9'd224, 9'd192, 9'd176, 9'd160, 9'd144, 9'd128,
        9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd32, 9'd0};
    localparam logic [15:0][KBPS_W-1:0] KBPS_ROW4 = {
        9'd0, 9'd160, 9'd144, 9'd128, 9'd112, 9'd96, 9'd80, 9'd64,
        9'd56, 9'd48, 9'd40, 9'd32, 9'd24, 9'd16, 9'd8, 9'd0};

    // One-hot states of the front end.
    typedef enum logic [6:0] {
        ST_HEAD  = 7'b0000001,
        ST_CLASS = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_FIN   = 7'b0001000,
        ST_FRAME = 7'b0010000,
        ST_TAG   = 7'b0100000,
        ST_ID3   = 7'b1000000
    } mafs_state_t;

    // One queue entry: one body byte or all four header bytes.
    typedef struct packed {
        logic [HDR_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [1:0]                       nlast;
        logic                             kind;
        logic                             first;
        logic                             last;
        logic [LEN_W-1:0]                 total;
    } mafs_entry_t;

    // Write side of the queue.
    typedef struct packed {
        logic        valid;
        mafs_entry_t entry;
    } mafs_push_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } mafs_q_status_t;

    // Bitrate in kbps for a table row and a bitrate index.
    function automatic logic [KBPS_W-1:0] kbps_lookup(input logic [2:0] row,
                                                       input logic [3:0] idx);
        logic [KBPS_W-1:0] kb;
        case (row)
            3'd0:    kb = KBPS_ROW0[idx];
            3'd1:    kb = KBPS_ROW1[idx];
            3'd2:    kb = KBPS_ROW2[idx];
            3'd3:    kb = KBPS_ROW3[idx];
            3'd4:    kb = KBPS_ROW4[idx];
            default: kb = '0;
        endcase
        return kb;
    endfunction

    // MPEG 1 sample rate for a rate index.
    function automatic logic [RATE_W-1:0] rate_base(input logic [1:0] sri);
        logic [RATE_W-1:0] r;
        case (sri)
            2'd0:    r = 16'd44100;
            2'd1:    r = 16'd48000;
            2'd2:    r = 16'd32000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/mafs_front.sv
// Front end: accepts bytes, gathers and classifies headers, queues results.
`default_nettype none
`include "mpeg_audio_frame_sync_top_assert.svh"

module mafs_front import mafs_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [BYTE_W-1:0]    data_byte,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data,
    input  wire mafs_q_status_t       q_status,
    output mafs_push_t                push
);

    localparam int STEP_W = $clog2(QUO_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);
    localparam int FULL_W = QUO_W + 3;

    // Control state.
    mafs_state_t            state_reg, state_next;
    logic                   hunting_reg, hunting_next;
    logic [LEN_W-1:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [LEN_W-1:0]       tag_len_reg, tag_len_next;
    logic [LEN_W-1:0]       id3_len_reg, id3_len_next;
    logic [STEP_W-1:0]      step_reg, step_next;

    // Header bytes and divider datapath.
    logic [HDR_BYTES-1:0][BYTE_W-1:0] hdr_reg, hdr_next;
    logic [RATE_W-1:0]      rem_reg, rem_next;
    logic [QUO_W-1:0]       lo_reg, lo_next;
    logic [QUO_W-1:0]       quo_reg, quo_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic                   pad_reg, pad_next;
    logic                   l1_reg, l1_next;

    logic                   accept;
    logic [1:0]             ver, lay, sri;
    logic [3:0]             bri;
    logic                   legal, is_sync, is_tag, is_id3;
    logic [2:0]             row;
    logic [1:0]             rate_shift;
    logic [RATE_W-1:0]      rate;
    logic [COEF_W-1:0]      coef;
    logic [KBPS_W-1:0]      kb;
    logic [NUM_W-1:0]       num;
    logic [LEN_W-1:0]       tag_min, id3_min;
    logic [RATE_W:0]        trial;
    logic                   qbit;
    logic [QUO_W:0]         qp;
    logic [FULL_W-1:0]      len_full;
    logic                   over;
    logic [HDR_BYTES-1:0][BYTE_W-1:0] drop_hdr;
    logic [LEN_W-1:0]       drop_cnt;
    logic                   drop_hunt;
    logic [LEN_W-1:0]       cnt_inc;
    logic                   body_done;

    // Shortest block is the header itself.
    function automatic logic [LEN_W-1:0] at_least4(input logic [LEN_W-1:0] v);
        return (v < MIN_BLOCK) ? MIN_BLOCK : v;
    endfunction

    // Handshakes: the header is classified while the input waits.
    assign cfg_ready = 1'b1;
    assign in_stall  = ~((state_reg == ST_HEAD) || (state_reg == ST_TAG) ||
                         (((state_reg == ST_FRAME) || (state_reg == ST_ID3)) &&
                          !q_status.full));
    assign accept    = in_valid && !in_stall;

    // Header field decode and the numerator of the frame length.
    always_comb
    begin
        ver   = hdr_reg[1][4:3];
        lay   = hdr_reg[1][2:1];
        bri   = hdr_reg[2][7:4];
        sri   = hdr_reg[2][3:2];
        legal = (bri != BRI_FREE) && (bri != BRI_BAD) && (sri != SRI_RESERVED) &&
                (ver != VER_RESERVED) && (lay != LAY_RESERVED);
        if (ver == VER_MPEG1)
        begin
            row = 3'(2'd3 - lay);
        end
        else
        begin
            row = (lay == LAY_I) ? 3'd3 : 3'd4;
        end
        rate_shift = (ver == VER_MPEG1) ? 2'd0 : (ver == VER_MPEG2) ? 2'd1 : 2'd2;
        rate       = rate_base(sri) >> rate_shift;
        if (lay == LAY_I)
        begin
            coef = COEF_L1;
        end
        else if (ver != VER_MPEG1 && lay == LAY_III)
        begin
            coef = COEF_L3_LSF;
        end
        else
        begin
            coef = COEF_STD;
        end
        kb      = kbps_lookup(row, bri);
        num     = NUM_W'(coef) * NUM_W'(kb);
        is_sync = (hdr_reg[0] == SYNC_BYTE) &&
                  ((hdr_reg[1] & SYNC_MASK) == SYNC_MASK) && legal;
        is_tag  = (hdr_reg[0] == CHAR_T) && (hdr_reg[1] == CHAR_A) &&
                  (hdr_reg[2] == CHAR_G);
        is_id3  = (hdr_reg[0] == CHAR_I) && (hdr_reg[1] == CHAR_D) &&
                  (hdr_reg[2] == CHAR_3);
        tag_min = at_least4(tag_len_reg);
        id3_min = at_least4(id3_len_reg);
    end

    // Restoring divide step and the final frame length.
    always_comb
    begin
        trial    = {rem_reg, lo_reg[QUO_W-1]};
        qbit     = trial >= {1'b0, rate_reg};
        qp       = {1'b0, quo_reg} + (QUO_W + 1)'(pad_reg);
        len_full = l1_reg ? {qp, 2'b00} : {2'b00, qp};
        over     = 32'(len_full) > 32'(MAX_FRAME_BYTES);
    end

    // Resync after a bad header: keep the held bytes from the next sync byte on.
    always_comb
    begin
        drop_hdr  = hdr_reg;
        drop_hunt = 1'b0;
        if (hdr_reg[1] == SYNC_BYTE)
        begin
            drop_hdr[0] = hdr_reg[1];
            drop_hdr[1] = hdr_reg[2];
            drop_hdr[2] = hdr_reg[3];
            drop_cnt    = 12'd3;
        end
        else if (hdr_reg[2] == SYNC_BYTE)
        begin
            drop_hdr[0] = hdr_reg[2];
            drop_hdr[1] = hdr_reg[3];
            drop_cnt    = 12'd2;
        end
        else if (hdr_reg[3] == SYNC_BYTE)
        begin
            drop_hdr[0] = hdr_reg[3];
            drop_cnt    = 12'd1;
        end
        else
        begin
            drop_cnt  = 12'd0;
            drop_hunt = 1'b1;
        end
    end

    assign cnt_inc   = cnt_reg + 12'd1;
    assign body_done = cnt_inc >= len_reg;

    // Main sequencer.
    always_comb
    begin
        state_next   = state_reg;
        hunting_next = hunting_reg;
        cnt_next     = cnt_reg;
        len_next     = len_reg;
        tag_len_next = tag_len_reg;
        id3_len_next = id3_len_reg;
        step_next    = step_reg;
        hdr_next     = hdr_reg;
        rem_next     = rem_reg;
        lo_next      = lo_reg;
        quo_next     = quo_reg;
        rate_next    = rate_reg;
        pad_next     = pad_reg;
        l1_next      = l1_reg;

        push.valid       = 1'b0;
        push.entry.bytes = hdr_reg;
        push.entry.nlast = 2'(HDR_BYTES - 1);
        push.entry.kind  = KIND_AUDIO;
        push.entry.first = 1'b1;
        push.entry.last  = 1'b0;
        push.entry.total = len_reg;

        // The user must write registers only while idle; not enforced here.
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TAG_SKIP: tag_len_next = cfg_data;
                CFG_ID3_LEN:  id3_len_next = cfg_data;
                default:      ;
            endcase
        end

        case (state_reg)
            ST_HEAD:
            begin
                if (accept && mode)
                begin
                    cnt_next     = '0;
                    len_next     = '0;
                    hunting_next = 1'b0;
                end
                else if (accept && !(hunting_reg && data_byte != SYNC_BYTE))
                begin
                    hunting_next         = 1'b0;
                    hdr_next[cnt_reg[1:0]] = data_byte;
                    cnt_next             = cnt_inc;
                    if (cnt_reg[1:0] == 2'(HDR_BYTES - 1))
                    begin
                        state_next = ST_CLASS;
                    end
                end
            end

            ST_CLASS:
            begin
                if (is_sync)
                begin
                    rem_next   = RATE_W'(num >> QUO_W);
                    lo_next    = num[QUO_W-1:0];
                    rate_next  = rate;
                    pad_next   = hdr_reg[2][1];
                    l1_next    = (lay == LAY_I);
                    step_next  = '0;
                    state_next = ST_DIV;
                end
                else if (is_tag)
                begin
                    len_next = tag_min;
                    if (tag_min <= MIN_BLOCK)
                    begin
                        cnt_next   = '0;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_TAG;
                    end
                end
                else if (is_id3)
                begin
                    if (!q_status.full)
                    begin
                        push.valid       = 1'b1;
                        push.entry.kind  = KIND_ID3;
                        push.entry.last  = (id3_min <= MIN_BLOCK);
                        push.entry.total = id3_min;
                        len_next         = id3_min;
                        if (id3_min <= MIN_BLOCK)
                        begin
                            cnt_next   = '0;
                            state_next = ST_HEAD;
                        end
                        else
                        begin
                            state_next = ST_ID3;
                        end
                    end
                end
                else
                begin
                    hdr_next     = drop_hdr;
                    cnt_next     = drop_cnt;
                    hunting_next = drop_hunt;
                    state_next   = ST_HEAD;
                end
            end

            // One quotient bit per cycle.
            ST_DIV:
            begin
                if (qbit)
                begin
                    rem_next = RATE_W'(trial - {1'b0, rate_reg});
                end
                else
                begin
                    rem_next = trial[RATE_W-1:0];
                end
                lo_next   = {lo_reg[QUO_W-2:0], 1'b0};
                quo_next  = {quo_reg[QUO_W-2:0], qbit};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (over)
                begin
                    hdr_next     = drop_hdr;
                    cnt_next     = drop_cnt;
                    hunting_next = drop_hunt;
                    state_next   = ST_HEAD;
                end
                else if (!q_status.full)
                begin
                    push.valid       = 1'b1;
                    push.entry.last  = (len_full <= FULL_W'(HDR_BYTES));
                    push.entry.total = len_full[LEN_W-1:0];
                    len_next         = len_full[LEN_W-1:0];
                    if (len_full <= FULL_W'(HDR_BYTES))
                    begin
                        cnt_next   = '0;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        state_next = ST_FRAME;
                    end
                end
            end

            ST_FRAME, ST_TAG, ST_ID3:
            begin
                if (accept && mode)
                begin
                    cnt_next     = '0;
                    len_next     = '0;
                    hunting_next = 1'b0;
                    state_next   = ST_HEAD;
                end
                else if (accept)
                begin
                    push.valid       = (state_reg != ST_TAG);
                    push.entry.bytes = {{((HDR_BYTES - 1) * BYTE_W){1'b0}}, data_byte};
                    push.entry.nlast = 2'd0;
                    push.entry.kind  = (state_reg == ST_ID3) ? KIND_ID3 : KIND_AUDIO;
                    push.entry.first = 1'b0;
                    push.entry.last  = body_done;
                    if (body_done)
                    begin
                        cnt_next   = '0;
                        state_next = ST_HEAD;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end

            default:
            begin
                state_next = ST_HEAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_HEAD;
            hunting_reg <= 1'b0;
            cnt_reg     <= '0;
            len_reg     <= '0;
            tag_len_reg <= TAG_SKIP_RESET;
            id3_len_reg <= ID3_LEN_RESET;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            hunting_reg <= hunting_next;
            cnt_reg     <= cnt_next;
            len_reg     <= len_next;
            tag_len_reg <= tag_len_next;
            id3_len_reg <= id3_len_next;
            step_reg    <= step_next;
        end
    end

    // Header and divider datapath registers.
    always_ff @(posedge clk)
    begin
        hdr_reg  <= hdr_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        quo_reg  <= quo_next;
        rate_reg <= rate_next;
        pad_reg  <= pad_next;
        l1_reg   <= l1_next;
    end

    // While gathering, fewer than four header bytes are ever held.
    `MAFS_ASSERT(a_head_count, (state_reg == ST_HEAD) |-> (cnt_reg < MIN_BLOCK), "header count overrun")
    // The divider always finishes after its last quotient bit.
    `MAFS_ASSERT(a_div_exit, (state_reg == ST_DIV && step_reg == DIV_LAST) |=> (state_reg == ST_FIN), "divider did not finish")

endmodule

`default_nettype wire

FILE: design/mafs_queue.sv
// Short queue of result entries between the front end and the output stage.
`default_nettype none
`include "mpeg_audio_frame_sync_top_assert.svh"

module mafs_queue import mafs_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mafs_push_t  push,
    input  wire logic        pop,
    output mafs_entry_t      head,
    output mafs_q_status_t   q_status
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    mafs_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_W'(DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = mem_reg[rd_ptr_reg];
    assign count_next     = count_reg + CNT_W'(push.valid) - CNT_W'(pop);

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `MAFS_NEVER(a_no_overflow, push.valid && q_status.full, "push into a full queue")
    `MAFS_NEVER(a_no_underflow, pop && q_status.empty, "pop from an empty queue")

endmodule

`default_nettype wire

FILE: design/mafs_back.sv
// Output stage: splits queue entries into single result bytes.
`default_nettype none

module mafs_back import mafs_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mafs_entry_t      head,
    input  wire mafs_q_status_t   q_status,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  block_kind,
    output logic                  block_first,
    output logic                  block_last,
    output logic [LEN_W-1:0]      block_total
);

    logic              out_valid_reg, out_valid_next;
    logic [1:0]        idx_reg, idx_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              kind_reg, first_reg, last_reg;
    logic [LEN_W-1:0]  total_reg;
    logic              load;
    logic              at_end;

    // Load the next byte when the output register is free or being taken.
    assign load   = !q_status.empty && (!out_valid_reg || !out_stall);
    assign at_end = (idx_reg == head.nlast);
    assign pop    = load && at_end;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            idx_next       = at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

    // Output control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= head.bytes[idx_reg];
            kind_reg  <= head.kind;
            first_reg <= head.first && (idx_reg == 2'd0);
            last_reg  <= head.last && at_end;
            total_reg <= head.total;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = byte_reg;
    assign block_kind  = kind_reg;
    assign block_first = first_reg;
    assign block_last  = last_reg;
    assign block_total = total_reg;

endmodule

`default_nettype wire

FILE: design/mpeg_audio_frame_sync_top.sv
// Top level of the MPEG audio frame synchronizer.
//
// The input channel (in_valid/in_stall) carries one transaction per stream
// byte; mode high instead aborts and resynchronizes without a result. The
// output channel (out_valid/out_stall) carries one transaction per byte of a
// recognized audio frame or ID3 block, with first/last marks, the kind and
// the block's total length. TAG blocks are discarded. The config channel
// (cfg_valid/cfg_ready, always ready) writes the TAG and ID3 block lengths.
// Body bytes are taken one per cycle while the queue has room and pass
// through the queue and the output register. After the fourth header byte
// the input stalls for classification and, for an audio header, through the
// frame length divider, which produces one quotient bit per cycle. Unless the
// receiver stalls, header bytes then leave one per cycle as body bytes come.
// A four-entry queue separates the front end from the output register, so a
// stalled receiver backs up into in_stall only once the queue is full.
// Reset empties the queue, returns to header hunting and loads the register
// defaults (TAG 128, ID3 24); no clearing pass is needed.
`default_nettype none

module mpeg_audio_frame_sync_top import mafs_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 mode,
    input  wire logic [BYTE_W-1:0]    data_byte,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [BYTE_W-1:0]         out_byte,
    output logic                      block_kind,
    output logic                      block_first,
    output logic                      block_last,
    output logic [LEN_W-1:0]          block_total,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [LEN_W-1:0]     cfg_data
);

    mafs_push_t     push;
    mafs_q_status_t q_status;
    mafs_entry_t    head;
    logic           pop;

    // Header classification and byte routing.
    mafs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push)
    );

    // Decoupling queue.
    mafs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    // Output serializer.
    mafs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .block_kind  (block_kind),
        .block_first (block_first),
        .block_last  (block_last),
        .block_total (block_total)
    );

endmodule

`default_nettype wire

FILE: bench/mpeg_audio_frame_sync_top_tb.sv
// Self-checking testbench for the MPEG audio frame synchronizer top level.
`default_nettype none

module mpeg_audio_frame_sync_top_tb;
    import mafs_pkg::*;

    // Bench timing and traffic limits.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 150;
    localparam int SHORT_LIMIT    = 64;
    localparam int MEDIUM_FRAME   = 420;
    localparam int PHASE_ITEMS    = 35;
    localparam int PHASE_SEGMENTS = 6;

    // Header codes that the package does not name.
    localparam logic [1:0] VER_MPEG25 = 2'd0;
    localparam logic [1:0] LAY_II     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Bytes per kbps per Hz for the three frame formulas.
    localparam int unsigned SLOT_COEF = 12000;
    localparam int unsigned LSF_COEF  = 72000;
    localparam int unsigned STD_COEF  = 144000;

    // Frame flavors for the stimulus generator.
    localparam int FLAVOR_SMALL   = 0;
    localparam int FLAVOR_MEDIUM  = 1;
    localparam int FLAVOR_ANY     = 2;
    localparam int FLAVOR_LARGEST = 3;

    typedef enum logic [1:0] {
        SEEK_HEADER,
        IN_FRAME,
        IN_TAG,
        IN_ID3
    } sync_phase_t;

    typedef struct packed {
        logic             abort;
        logic [7:0]       value;
    } stream_item_t;

    typedef struct packed {
        logic [7:0]       value;
        logic             kind;
        logic             is_first;
        logic             is_last;
        logic [LEN_W-1:0] total;
    } frame_byte_t;

    // Bitrate rows in kbps and MPEG 1 sample rates.
    int unsigned kbps_table [5][16] = '{
        '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
        '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
        '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
        '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
    };
    int unsigned base_rates [3] = '{44100, 48000, 32000};

    // Block ports.
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 mode = 1'b0;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 block_kind;
    logic                 block_first;
    logic                 block_last;
    logic [LEN_W-1:0]     block_total;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0]     cfg_data = '0;

    // Predictor state and registers.
    sync_phase_t      sync_phase = SEEK_HEADER;
    logic [7:0]       sync_hdr [4] = '{8'h00, 8'h00, 8'h00, 8'h00};
    int unsigned      sync_count = 0;
    int unsigned      sync_len = 0;
    bit               sync_hunting = 1'b0;
    logic [LEN_W-1:0] tag_len_reg = TAG_SKIP_RESET;
    logic [LEN_W-1:0] id3_len_reg = ID3_LEN_RESET;

    // Stimulus, expectations and bookkeeping.
    stream_item_t stream_items [$];
    frame_byte_t  expected_bytes [$];
    int unsigned  items_queued = 0;
    int unsigned  items_taken = 0;
    int unsigned  phase_items = 0;
    int unsigned  mismatches = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           hold_left = 0;
    bit           hold_done = 1'b0;
    int unsigned  outs_seen = 0;
    int           pattern_left = 0;
    int           pattern_kind = 0;
    int           idle_cycles = 0;

    mpeg_audio_frame_sync_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .block_kind  (block_kind),
        .block_first (block_first),
        .block_last  (block_last),
        .block_total (block_total),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Frame length in bytes from header bytes 1 and 2, zero when illegal or too long.
    function automatic int unsigned frame_bytes(input logic [7:0] h1, input logic [7:0] h2);
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [1:0]  sri;
        logic [3:0]  bri;
        int unsigned pad;
        int unsigned row;
        int unsigned rate;
        int unsigned kb;
        int unsigned len;
        ver = h1[4:3];
        lay = h1[2:1];
        bri = h2[7:4];
        sri = h2[3:2];
        pad = h2[1];
        if (bri == BRI_FREE || bri == BRI_BAD || sri == SRI_RESERVED
            || ver == VER_RESERVED || lay == LAY_RESERVED)
            return 0;
        if (ver == VER_MPEG1)
            row = 3 - int'(lay);
        else
            row = (lay == LAY_I) ? 3 : 4;
        rate = base_rates[sri] >> ((ver == VER_MPEG1) ? 0 : (ver == VER_MPEG2) ? 1 : 2);
        kb = kbps_table[row][bri];
        if (lay == LAY_I)
            len = ((SLOT_COEF * kb) / rate + pad) * 4;
        else if (ver != VER_MPEG1 && lay == LAY_III)
            len = (LSF_COEF * kb) / rate + pad;
        else
            len = (STD_COEF * kb) / rate + pad;
        if (len > MAX_FRAME_BYTES)
            return 0;
        return len;
    endfunction

    task automatic add_expected_byte(input logic [7:0] value, input logic kind,
                                     input logic is_first, input logic is_last);
        frame_byte_t fb;
        fb.value = value;
        fb.kind = kind;
        fb.is_first = is_first;
        fb.is_last = is_last;
        fb.total = LEN_W'(sync_len);
        expected_bytes.push_back(fb);
    endtask

    // Advance the predicted synchronizer by one accepted transaction.
    task automatic predict_item(input logic abort, input logic [7:0] b);
        int unsigned flen;
        logic        kind;
        if (abort)
        begin
            sync_phase = SEEK_HEADER;
            sync_count = 0;
            sync_len = 0;
            sync_hunting = 1'b0;
            return;
        end
        if (sync_phase == SEEK_HEADER)
        begin
            if (sync_hunting && b != SYNC_BYTE)
                return;
            sync_hunting = 1'b0;
            sync_hdr[sync_count % 4] = b;
            sync_count++;
            if (sync_count < 4)
                return;
            sync_count = 4;
            flen = frame_bytes(sync_hdr[1], sync_hdr[2]);
            if (sync_hdr[0] == SYNC_BYTE && (sync_hdr[1] & SYNC_MASK) == SYNC_MASK
                && flen != 0)
            begin
                sync_phase = IN_FRAME;
                sync_len = flen;
            end
            else if (sync_hdr[0] == CHAR_T && sync_hdr[1] == CHAR_A && sync_hdr[2] == CHAR_G)
            begin
                sync_phase = IN_TAG;
                sync_len = (tag_len_reg < MIN_BLOCK) ? MIN_BLOCK : tag_len_reg;
            end
            else if (sync_hdr[0] == CHAR_I && sync_hdr[1] == CHAR_D && sync_hdr[2] == CHAR_3)
            begin
                sync_phase = IN_ID3;
                sync_len = (id3_len_reg < MIN_BLOCK) ? MIN_BLOCK : id3_len_reg;
            end
            else
            begin
                // Bad header: shift until the held bytes start with a sync byte.
                do
                begin
                    sync_hdr[0] = sync_hdr[1];
                    sync_hdr[1] = sync_hdr[2];
                    sync_hdr[2] = sync_hdr[3];
                    sync_count--;
                end
                while (sync_count != 0 && sync_hdr[0] != SYNC_BYTE);
                if (sync_count == 0)
                    sync_hunting = 1'b1;
                return;
            end
            if (sync_phase != IN_TAG)
            begin
                kind = (sync_phase == IN_ID3) ? KIND_ID3 : KIND_AUDIO;
                for (int i = 0; i < 4; i++)
                    add_expected_byte(sync_hdr[i], kind, i == 0,
                                      i == 3 && sync_count >= sync_len);
            end
        end
        else
        begin
            sync_count++;
            if (sync_phase != IN_TAG)
                add_expected_byte(b, (sync_phase == IN_ID3) ? KIND_ID3 : KIND_AUDIO,
                                  1'b0, sync_count >= sync_len);
        end
        if (sync_count >= sync_len)
        begin
            sync_phase = SEEK_HEADER;
            sync_count = 0;
        end
    endtask

    // Input driver: bursts of transactions separated by random gaps.
    always @(posedge clk)
    begin : byte_driver
        stream_item_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_item(mode, data_byte);
                items_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (stream_items.size() > 0)
                begin
                    nxt = stream_items.pop_front();
                    in_valid <= 1'b1;
                    mode <= nxt.abort;
                    data_byte <= nxt.value;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off to back up the input.
    always @(posedge clk)
    begin : stall_pattern
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                outs_seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && outs_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_left = $urandom_range(10, 120);
                    pattern_kind = $urandom_range(0, 2);
                end
                pattern_left--;
                case (pattern_kind)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Output monitor: compare each transaction with the oldest expectation.
    always @(posedge clk)
    begin : out_monitor
        frame_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output byte %h (kind %b first %b last %b total %0d)",
                         $time, out_byte, block_kind, block_first, block_last, block_total);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.value, out_byte);
                    mismatches++;
                end
                if (block_kind !== want.kind)
                begin
                    $display("%0t: block_kind expected %b actual %b", $time, want.kind,
                             block_kind);
                    mismatches++;
                end
                if (block_first !== want.is_first)
                begin
                    $display("%0t: block_first expected %b actual %b", $time, want.is_first,
                             block_first);
                    mismatches++;
                end
                if (block_last !== want.is_last)
                begin
                    $display("%0t: block_last expected %b actual %b", $time, want.is_last,
                             block_last);
                    mismatches++;
                end
                if (block_total !== want.total)
                begin
                    $display("%0t: block_total expected %0d actual %0d", $time, want.total,
                             block_total);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** mpeg_audio_frame_sync_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic push_item(input logic abort, input logic [7:0] value, input bit counted);
        stream_item_t it;
        it.abort = abort;
        it.value = value;
        stream_items.push_back(it);
        items_queued++;
        if (counted)
            phase_items++;
    endtask

    task automatic push_body(input int n);
        for (int i = 0; i < n; i++)
            push_item(1'b0, 8'($urandom), 1'b1);
    endtask

    // One audio frame with random legal header fields, optionally cut by an abort.
    task automatic push_frame(input int flavor, input bit cut);
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [1:0]  sri;
        logic [3:0]  bri;
        logic        pad;
        logic [7:0]  h1;
        logic [7:0]  h2;
        int unsigned len;
        int          n;
        do
        begin
            case ($urandom_range(0, 2))
                0:       ver = VER_MPEG1;
                1:       ver = VER_MPEG2;
                default: ver = VER_MPEG25;
            endcase
            lay = 2'($urandom_range(1, 3));
            bri = 4'($urandom_range(1, 14));
            sri = 2'($urandom_range(0, 2));
            pad = 1'($urandom);
            if (flavor == FLAVOR_SMALL)
            begin
                ver = VER_MPEG25;
                lay = LAY_III;
                bri = 4'd1;
            end
            else if (flavor == FLAVOR_LARGEST)
            begin
                ver = VER_MPEG25;
                lay = LAY_II;
                bri = 4'd14;
                sri = 2'd2;
                pad = 1'b1;
            end
            h1 = {3'b111, ver, lay, 1'($urandom)};
            h2 = {bri, sri, pad, 1'($urandom)};
            len = frame_bytes(h1, h2);
        end
        while (flavor == FLAVOR_MEDIUM && len > MEDIUM_FRAME);
        push_item(1'b0, SYNC_BYTE, 1'b1);
        push_item(1'b0, h1, 1'b1);
        push_item(1'b0, h2, 1'b1);
        push_item(1'b0, 8'($urandom), 1'b1);
        n = len - 4;
        if (cut)
            n = $urandom_range(0, n - 1);
        push_body(n);
        if (cut)
            push_item(1'b1, 8'($urandom), 1'b1);
    endtask

    // A TAG or ID3 block at the current register length, optionally cut.
    task automatic push_marked_block(input bit is_id3, input bit cut);
        logic [LEN_W-1:0] reg_len;
        int               n;
        reg_len = is_id3 ? id3_len_reg : tag_len_reg;
        if (reg_len < MIN_BLOCK)
            reg_len = MIN_BLOCK;
        push_item(1'b0, is_id3 ? CHAR_I : CHAR_T, 1'b1);
        push_item(1'b0, is_id3 ? CHAR_D : CHAR_A, 1'b1);
        push_item(1'b0, is_id3 ? CHAR_3 : CHAR_G, 1'b1);
        n = int'(reg_len) - 3;
        if (cut)
            n = $urandom_range(0, n - 1);
        push_body(n);
        if (cut)
            push_item(1'b1, 8'($urandom), 1'b1);
    endtask

    // A sync byte followed by a header with an illegal field or broken sync bits.
    task automatic push_bad_header();
        logic [7:0] h1;
        logic [7:0] h2;
        h1 = {3'b111, 5'($urandom)};
        h2 = 8'($urandom);
        case ($urandom_range(0, 5))
            0:       h2[7:4] = BRI_FREE;
            1:       h2[7:4] = BRI_BAD;
            2:       h2[3:2] = SRI_RESERVED;
            3:       h1[4:3] = VER_RESERVED;
            4:       h1[2:1] = LAY_RESERVED;
            default: h1[7:5] = 3'($urandom_range(0, 6));
        endcase
        push_item(1'b0, SYNC_BYTE, 1'b1);
        push_item(1'b0, h1, 1'b1);
        push_item(1'b0, h2, 1'b1);
        push_item(1'b0, 8'($urandom), 1'b1);
    endtask

    // Line noise with occasional sync bytes, sometimes followed by an abort.
    task automatic push_noise();
        int n;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            push_item(1'b0, ($urandom_range(0, 4) == 0) ? SYNC_BYTE : 8'($urandom), 1'b0);
        if ($urandom_range(0, 1) == 0)
            push_item(1'b1, 8'($urandom), 1'b1);
    endtask

    // Mostly whole frames and blocks, with noise, bad headers and aborts mixed in.
    task automatic run_random_phase();
        int segs;
        int r;
        int f;
        bit long_id3;
        bit long_tag;
        phase_items = 0;
        segs = 0;
        long_id3 = id3_len_reg > SHORT_LIMIT;
        long_tag = tag_len_reg > SHORT_LIMIT;
        while (phase_items < PHASE_ITEMS || segs < PHASE_SEGMENTS)
        begin
            r = $urandom_range(0, 99);
            f = $urandom_range(0, 19);
            f = (f < 12) ? FLAVOR_SMALL : (f < 19) ? FLAVOR_MEDIUM : FLAVOR_ANY;
            if (r < 55)
                push_frame(f, $urandom_range(0, 9) == 0);
            else if (r < 65)
            begin
                if (!long_id3 || $urandom_range(0, 19) == 0)
                    push_marked_block(1'b1, $urandom_range(0, 7) == 0);
                else
                    push_frame(FLAVOR_SMALL, 1'b0);
            end
            else if (r < 75)
            begin
                if (!long_tag || $urandom_range(0, 19) == 0)
                    push_marked_block(1'b0, $urandom_range(0, 7) == 0);
                else
                    push_frame(FLAVOR_SMALL, 1'b0);
            end
            else if (r < 85)
                push_bad_header();
            else if (r < 95)
                push_noise();
            else
                push_item(1'b1, 8'($urandom), 1'b1);
            segs++;
        end
    endtask

    // Wait until every queued transaction is taken and every result has come.
    task automatic drain_stream();
        do
            @(posedge clk);
        while (items_taken != items_queued || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TAG_SKIP)
            tag_len_reg = value;
        else if (idx == CFG_ID3_LEN)
            id3_len_reg = value;
    endtask

    // Test sequence: directed cases, then random phases over several settings.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Abort at start, a bad header that leaves hunting, a dropped byte while
        // hunting, a resync inside the header, an illegal bitrate and an abort
        // in the middle of a header.
        push_item(1'b1, 8'h00, 1'b1);
        push_item(1'b0, 8'h12, 1'b1);
        push_item(1'b0, 8'h34, 1'b1);
        push_item(1'b0, 8'h56, 1'b1);
        push_item(1'b0, 8'h78, 1'b1);
        push_item(1'b0, 8'h00, 1'b1);
        push_item(1'b0, SYNC_BYTE, 1'b1);
        push_item(1'b0, 8'h1f, 1'b1);
        push_item(1'b0, SYNC_BYTE, 1'b1);
        push_item(1'b0, SYNC_MASK, 1'b1);
        push_item(1'b0, 8'h00, 1'b1);
        push_item(1'b0, 8'h11, 1'b1);
        push_item(1'b0, SYNC_BYTE, 1'b1);
        push_item(1'b0, 8'hfb, 1'b1);
        push_item(1'b0, 8'hf0, 1'b1);
        push_item(1'b0, 8'h00, 1'b1);
        push_item(1'b0, SYNC_BYTE, 1'b1);
        push_item(1'b0, 8'hfb, 1'b1);
        push_item(1'b1, 8'hff, 1'b1);
        drain_stream();

        // Register values below the shortest block, and an unused index.
        write_reg(CFG_TAG_SKIP, 12'd3);
        write_reg(CFG_ID3_LEN, 12'd0);
        write_reg(CFG_UNUSED, 12'hfff);
        push_marked_block(1'b0, 1'b0);
        push_marked_block(1'b1, 1'b0);
        drain_stream();

        // Random phases: low extreme, small random, high extreme, mixed.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_TAG_SKIP, MIN_BLOCK);
                    write_reg(CFG_ID3_LEN, MIN_BLOCK);
                end
                1:
                begin
                    write_reg(CFG_TAG_SKIP, LEN_W'($urandom_range(5, 40)));
                    write_reg(CFG_ID3_LEN, LEN_W'($urandom_range(5, 40)));
                end
                2:
                begin
                    write_reg(CFG_TAG_SKIP, 12'hfff);
                    write_reg(CFG_ID3_LEN, 12'hfff);
                end
                default:
                begin
                    write_reg(CFG_TAG_SKIP, LEN_W'($urandom_range(4, 200)));
                    write_reg(CFG_ID3_LEN, LEN_W'($urandom_range(4, 60)));
                end
            endcase
            if (p == 2)
            begin
                // Longest blocks and the longest frame, once each.
                push_marked_block(1'b0, 1'b0);
                push_marked_block(1'b1, 1'b0);
                push_frame(FLAVOR_LARGEST, 1'b0);
            end
            run_random_phase();
            drain_stream();
        end

        if (mismatches == 0)
            $display("** mpeg_audio_frame_sync_top: PASSED **");
        else
            $display("** mpeg_audio_frame_sync_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
